// ===== rtl/core/lrpg_pkg.sv =====
`timescale 1ns / 1ps

package lrpg_pkg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 1'd1;
    localparam logic [15:0] NUM_SAMPLES_RST = 16'd1;
    localparam logic [4:0] NUM_DIMS_RST = 5'd9;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [3:0]         dim_select;
        logic [15:0]        generator_value;
        logic signed [15:0] lower_bound;
        logic signed [15:0] upper_bound;
        logic [15:0]        sample_index;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         dim_out;
        logic signed [15:0] point_value;
        logic               last_of_sample;
    } pt_t;

    typedef struct packed {
        logic [15:0] gen;
        logic [15:0] lo;
        logic [15:0] hi;
    } tbl_entry_t;

    localparam int unsigned UPC_W = 4;

    typedef enum logic [2:0] {
        DP_NOP       = 3'd0,
        DP_ACCEPT    = 3'd1,
        DP_MUL_IDX   = 3'd2,
        DP_START_MOD = 3'd3,
        DP_MUL_SPAN  = 3'd4,
        DP_START_DIV = 3'd5,
        DP_EMIT      = 3'd6,
        DP_NEXT_DIM  = 3'd7
    } dp_op_t;

    typedef enum logic [2:0] {
        CND_NEVER     = 3'd0,
        CND_ALWAYS    = 3'd1,
        CND_NO_GEN    = 3'd2,
        CND_NO_DIMS   = 3'd3,
        CND_DIV_BUSY  = 3'd4,
        CND_OUT_BUSY  = 3'd5,
        CND_MORE_DIMS = 3'd6
    } cond_t;

    typedef struct packed {
        dp_op_t           op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ucw_t;

    typedef struct packed {
        logic gen_req;
        logic no_dims;
        logic div_busy;
        logic out_busy;
        logic more_dims;
    } seq_flags_t;

    localparam logic [UPC_W-1:0] UPC_ACCEPT    = 4'd0;
    localparam logic [UPC_W-1:0] UPC_DIM       = 4'd1;
    localparam logic [UPC_W-1:0] UPC_MUL_IDX   = 4'd2;
    localparam logic [UPC_W-1:0] UPC_START_MOD = 4'd3;
    localparam logic [UPC_W-1:0] UPC_MOD_WAIT  = 4'd4;
    localparam logic [UPC_W-1:0] UPC_MUL_SPAN  = 4'd5;
    localparam logic [UPC_W-1:0] UPC_START_DIV = 4'd6;
    localparam logic [UPC_W-1:0] UPC_DIV_WAIT  = 4'd7;
    localparam logic [UPC_W-1:0] UPC_EMIT      = 4'd8;
    localparam logic [UPC_W-1:0] UPC_NEXT      = 4'd9;
    localparam logic [UPC_W-1:0] UPC_DONE      = 4'd10;

    function automatic ucw_t ucode_word(input logic [UPC_W-1:0] pc);
        ucw_t w;
        unique case (pc)
            UPC_ACCEPT:    w = '{op: DP_ACCEPT,    cond: CND_NO_GEN,    target: UPC_ACCEPT};
            UPC_DIM:       w = '{op: DP_NOP,       cond: CND_NO_DIMS,   target: UPC_ACCEPT};
            UPC_MUL_IDX:   w = '{op: DP_MUL_IDX,   cond: CND_NEVER,     target: UPC_ACCEPT};
            UPC_START_MOD: w = '{op: DP_START_MOD, cond: CND_NEVER,     target: UPC_ACCEPT};
            UPC_MOD_WAIT:  w = '{op: DP_NOP,       cond: CND_DIV_BUSY,  target: UPC_MOD_WAIT};
            UPC_MUL_SPAN:  w = '{op: DP_MUL_SPAN,  cond: CND_NEVER,     target: UPC_ACCEPT};
            UPC_START_DIV: w = '{op: DP_START_DIV, cond: CND_NEVER,     target: UPC_ACCEPT};
            UPC_DIV_WAIT:  w = '{op: DP_NOP,       cond: CND_DIV_BUSY,  target: UPC_DIV_WAIT};
            UPC_EMIT:      w = '{op: DP_EMIT,      cond: CND_OUT_BUSY,  target: UPC_EMIT};
            UPC_NEXT:      w = '{op: DP_NEXT_DIM,  cond: CND_MORE_DIMS, target: UPC_DIM};
            UPC_DONE:      w = '{op: DP_NOP,       cond: CND_ALWAYS,    target: UPC_ACCEPT};
            default:       w = '{op: DP_NOP,       cond: CND_ALWAYS,    target: UPC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/lrpg_ram.sv =====
`timescale 1ns / 1ps

module lrpg_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/lrpg_div.sv =====
`timescale 1ns / 1ps

module lrpg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);

    logic [31:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] shifted;
    logic [16:0] diff;

    // One quotient bit per cycle, restoring.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[31]};
        diff      = shifted - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[16])
            begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[15:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next  = cnt_reg - 5'd1;
            busy_next = (cnt_reg != 5'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/lrpg_seq.sv =====
`timescale 1ns / 1ps

module lrpg_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  lrpg_pkg::seq_flags_t flags,
    output lrpg_pkg::ucw_t      ctrl
);

    import lrpg_pkg::*;

    logic [UPC_W-1:0] pc_reg, pc_next;
    ucw_t             word;
    logic             take;

    always_comb
    begin
        word = ucode_word(pc_reg);
        unique case (word.cond)
            CND_NEVER:     take = 1'b0;
            CND_ALWAYS:    take = 1'b1;
            CND_NO_GEN:    take = !flags.gen_req;
            CND_NO_DIMS:   take = flags.no_dims;
            CND_DIV_BUSY:  take = flags.div_busy;
            CND_OUT_BUSY:  take = flags.out_busy;
            CND_MORE_DIMS: take = flags.more_dims;
            default:       take = 1'b1;
        endcase
        pc_next = take ? word.target : pc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= UPC_ACCEPT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = word;

endmodule

// ===== rtl/core/lattice_rule_point_generator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload  Handshake
// cmd       in         cmd_t    cmd_valid / cmd_stall
// pt        out        pt_t     pt_valid / pt_stall
// cfg       in         16 bit   cfg_we, cfg_index
//
// A load writes the table as it is accepted. A generate runs the shared
// 32-step divider twice for every dimension. Reset sets the configuration to
// its defaults and the sequencer to its accept step; the tables hold garbage
// until loaded. A stalled result holds the sequencer at its output step while
// the next value waits in the divider.
module lattice_rule_point_generator #(
    parameter int unsigned MAX_DIMS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  lrpg_pkg::cmd_t                   cmd,
    output logic                             pt_valid,
    input  logic                             pt_stall,
    output lrpg_pkg::pt_t                    pt,
    input  logic                             cfg_we,
    input  logic [lrpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lrpg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import lrpg_pkg::*;

    localparam int unsigned AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned DCW = $clog2(MAX_DIMS + 1);
    localparam int unsigned CW  = (DCW > 5) ? DCW : 5;
    localparam int unsigned TW  = $bits(tbl_entry_t);

    logic [15:0]        num_samples_reg;
    logic [4:0]         num_dims_reg;
    logic [15:0]        idx_reg;
    logic [DCW-1:0]     d_reg, d_next;
    logic signed [32:0] prod_reg, prod_next;
    logic               neg_reg;
    logic               pt_valid_reg;
    pt_t                pt_reg;

    ucw_t               ctrl;
    seq_flags_t         flags;
    tbl_entry_t         entry;
    tbl_entry_t         wentry;
    logic [TW-1:0]      rdata;
    logic               tbl_we;
    logic               cmd_xfer;
    logic               emit;
    logic [15:0]        n_eff;
    logic [CW-1:0]      nd_ext;
    logic [DCW-1:0]     dims_eff;
    logic [DCW-1:0]     d_inc;
    logic               div_start;
    logic [31:0]        div_dividend;
    logic               div_busy;
    logic [31:0]        quo;
    logic [15:0]        rem;
    logic signed [16:0] span;
    logic signed [33:0] mul_span;
    logic [31:0]        mul_idx;
    logic [32:0]        prod_neg;
    logic [16:0]        q_adj;
    logic signed [17:0] offs;
    logic signed [17:0] val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_samples_reg <= NUM_SAMPLES_RST;
            num_dims_reg    <= NUM_DIMS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NUM_SAMPLES)
            begin
                num_samples_reg <= cfg_data;
            end
            else if (cfg_index == CFG_NUM_DIMS)
            begin
                num_dims_reg <= cfg_data[4:0];
            end
        end
    end

    assign n_eff    = (num_samples_reg == 16'd0) ? 16'd1 : num_samples_reg;
    assign nd_ext   = CW'(num_dims_reg);
    assign dims_eff = (nd_ext > CW'(MAX_DIMS)) ? DCW'(MAX_DIMS) : DCW'(nd_ext);
    assign d_inc    = d_reg + DCW'(1);

    assign cmd_stall = (ctrl.op != DP_ACCEPT);
    assign cmd_xfer  = cmd_valid && !cmd_stall;

    assign wentry = '{gen: cmd.generator_value, lo: cmd.lower_bound, hi: cmd.upper_bound};
    assign tbl_we = cmd_xfer && (cmd.operation == OP_LOAD)
                    && (7'(cmd.dim_select) < 7'(MAX_DIMS));

    lrpg_ram #(
        .WIDTH(TW),
        .DEPTH(MAX_DIMS)
    ) u_tbl (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(AW'(cmd.dim_select)),
        .wdata(wentry),
        .raddr(d_reg[AW-1:0]),
        .rdata(rdata)
    );

    assign entry = tbl_entry_t'(rdata);

    lrpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_eff),
        .busy     (div_busy),
        .quotient (quo),
        .remainder(rem)
    );

    assign flags = '{
        gen_req:   cmd_valid && (cmd.operation == OP_GENERATE),
        no_dims:   (dims_eff == '0),
        div_busy:  div_busy,
        out_busy:  pt_valid_reg && pt_stall,
        more_dims: (d_inc != dims_eff)
    };

    lrpg_seq u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .flags(flags),
        .ctrl (ctrl)
    );

    always_comb
    begin
        mul_idx      = idx_reg * entry.gen;
        span         = 17'(signed'(entry.hi)) - 17'(signed'(entry.lo));
        mul_span     = $signed({1'b0, rem}) * span;
        prod_neg     = -prod_reg;
        div_start    = (ctrl.op == DP_START_MOD) || (ctrl.op == DP_START_DIV);
        div_dividend = prod_reg[31:0];
        if (ctrl.op == DP_START_DIV && prod_reg[32])
        begin
            div_dividend = prod_neg[31:0];
        end
        prod_next = prod_reg;
        if (ctrl.op == DP_MUL_IDX)
        begin
            prod_next = {1'b0, mul_idx};
        end
        else if (ctrl.op == DP_MUL_SPAN)
        begin
            prod_next = mul_span[32:0];
        end
        q_adj = quo[16:0] + {16'd0, (rem != 16'd0)};
        offs  = neg_reg ? -$signed({1'b0, q_adj}) : $signed({1'b0, quo[16:0]});
        val   = 18'(signed'(entry.lo)) + offs;
        emit  = (ctrl.op == DP_EMIT) && !flags.out_busy;
        d_next = d_reg;
        if (cmd_xfer)
        begin
            d_next = '0;
        end
        else if (ctrl.op == DP_NEXT_DIM)
        begin
            d_next = d_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg <= 1'b0;
            d_reg        <= '0;
        end
        else
        begin
            d_reg <= d_next;
            if (emit)
            begin
                pt_valid_reg <= 1'b1;
            end
            else if (!pt_stall)
            begin
                pt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd_xfer)
        begin
            idx_reg <= cmd.sample_index;
        end
        if (ctrl.op == DP_START_DIV)
        begin
            neg_reg <= prod_reg[32];
        end
        if (emit)
        begin
            pt_reg.dim_out        <= 4'(d_reg);
            pt_reg.point_value    <= val[15:0];
            pt_reg.last_of_sample <= !flags.more_dims;
        end
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

endmodule

// ===== tb/sv/lattice_rule_point_generator_test.sv =====
`timescale 1ns / 1ps

module lattice_rule_point_generator_test;

    import lrpg_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CLOCK_PERIOD = 12;
    localparam int SETTLE_CYCLES = 2 + 73 * TABLE_DEPTH;
    localparam int HOLD_OFF_CYCLES = 2500;
    localparam int RANDOM_PER_PHASE = 54;
    localparam int REPORT_LIMIT = 25;
    localparam logic [15:0] LATTICE_SEED [9] = '{3, 7, 11, 13, 17, 19, 23, 29, 31};

    class point_scoreboard;
        logic [15:0] lattice_size;
        logic [4:0] dim_count;
        logic [15:0] gen_entry [TABLE_DEPTH];
        logic signed [15:0] low_entry [TABLE_DEPTH];
        logic signed [15:0] high_entry [TABLE_DEPTH];
        pt_t pending_points [$];
        int mismatches;
        int points_checked;
        int loads_seen;
        int generates_seen;

        function new();
            lattice_size = NUM_SAMPLES_RST;
            dim_count = NUM_DIMS_RST;
            mismatches = 0;
            points_checked = 0;
            loads_seen = 0;
            generates_seen = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_NUM_SAMPLES)
                lattice_size = data;
            else if (idx == CFG_NUM_DIMS)
                dim_count = data[4:0];
        endfunction

        // Each dimension yields low + floor(((i * z) mod N) * (high - low) / N).
        function void accept_command(cmd_t c);
            longint divisor;
            longint residue;
            longint product;
            longint quotient;
            int active_dims;
            int d;
            pt_t p;
            if (c.operation == OP_LOAD)
            begin
                gen_entry[c.dim_select] = c.generator_value;
                low_entry[c.dim_select] = c.lower_bound;
                high_entry[c.dim_select] = c.upper_bound;
                loads_seen++;
                return;
            end
            generates_seen++;
            divisor = (lattice_size == 0) ? 1 : longint'(lattice_size);
            active_dims = (dim_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(dim_count);
            for (d = 0; d < active_dims; d++)
            begin
                residue = (longint'(c.sample_index) * longint'(gen_entry[d])) % divisor;
                product = residue * (longint'(high_entry[d]) - longint'(low_entry[d]));
                quotient = product / divisor;
                if (product < 0 && product % divisor != 0)
                    quotient = quotient - 1;
                p.dim_out = 4'(d);
                p.point_value = 16'(longint'(low_entry[d]) + quotient);
                p.last_of_sample = (d == active_dims - 1);
                pending_points.insert(pending_points.size(), p);
            end
        endfunction

        function void report_mismatch(string field, logic signed [31:0] want,
                                      logic signed [31:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_point(pt_t got);
            pt_t want;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected transfer, expected none, got dim %0d value %0d",
                             $time, got.dim_out, got.point_value);
                return;
            end
            want = pending_points.pop_front();
            points_checked++;
            if (got.dim_out !== want.dim_out)
                report_mismatch("dim_out", want.dim_out, got.dim_out);
            if (got.point_value !== want.point_value)
                report_mismatch("point_value", want.point_value, got.point_value);
            if (got.last_of_sample !== want.last_of_sample)
                report_mismatch("last_of_sample", want.last_of_sample, got.last_of_sample);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic pt_valid;
    logic pt_stall = 1'b0;
    pt_t pt;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_NUM_SAMPLES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 6;
    int recv_idle_pct = 69;
    bit hold_off_request = 1'b0;
    point_scoreboard scoreboard = new();

    lattice_rule_point_generator #(
        .MAX_DIMS(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .pt_valid(pt_valid),
        .pt_stall(pt_stall),
        .pt(pt),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #(CLOCK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
            scoreboard.accept_command(cmd);
        if (rst_n && pt_valid && !pt_stall)
            scoreboard.check_point(pt);
    end

    // The long hold-off lets the generator fill up and stall incoming transfers.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                pt_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            pt_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial
    begin
        #(64'd30_000_000);
        $display("lattice_rule_point_generator verification failed");
        $finish;
    end

    function automatic logic signed [15:0] random_bound();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cmd_t load_item(logic [3:0] dim, logic [15:0] z,
                                       logic signed [15:0] lo, logic signed [15:0] hi);
        cmd_t c;
        c.operation = OP_LOAD;
        c.dim_select = dim;
        c.generator_value = z;
        c.lower_bound = lo;
        c.upper_bound = hi;
        c.sample_index = 16'($urandom);
        return c;
    endfunction

    function automatic cmd_t generate_item(logic [15:0] idx);
        cmd_t c;
        c.operation = OP_GENERATE;
        c.dim_select = 4'($urandom);
        c.generator_value = 16'($urandom);
        c.lower_bound = 16'($urandom);
        c.upper_bound = 16'($urandom);
        c.sample_index = idx;
        return c;
    endfunction

    function automatic cmd_t random_command();
        if ($urandom_range(0, 99) < 30)
            return load_item(4'($urandom), 16'($urandom), random_bound(), random_bound());
        return generate_item(16'($urandom));
    endfunction

    task automatic send_command(input cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] lattice_size, input logic [4:0] dims);
        cfg_we <= 1'b1;
        cfg_index <= CFG_NUM_SAMPLES;
        cfg_data <= lattice_size;
        @(posedge clk);
        scoreboard.write_register(CFG_NUM_SAMPLES, lattice_size);
        cfg_index <= CFG_NUM_DIMS;
        cfg_data <= CFG_DATA_W'(dims);
        @(posedge clk);
        scoreboard.write_register(CFG_NUM_DIMS, CFG_DATA_W'(dims));
        cfg_we <= 1'b0;
    endtask

    task automatic finish_phase();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (scoreboard.pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int k;
        for (k = 0; k < count; k++)
            send_command(random_command());
    endtask

    initial
    begin
        int k;
        int phase;
        logic [15:0] z;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings first: a lattice of one maps every value to its lower bound.
        for (k = 0; k < TABLE_DEPTH; k++)
        begin
            case (k)
                0:
                begin
                    z = 16'h0000;
                    lo = 16'sh8000;
                    hi = 16'sh7FFF;
                end
                1:
                begin
                    z = 16'hFFFF;
                    lo = 16'sh7FFF;
                    hi = 16'sh8000;
                end
                2:
                begin
                    z = 16'h0001;
                    lo = 16'sh8000;
                    hi = 16'sh8000;
                end
                default:
                begin
                    z = (k < 9) ? LATTICE_SEED[k] : 16'($urandom);
                    lo = random_bound();
                    hi = random_bound();
                end
            endcase
            send_command(load_item(4'(k), z, lo, hi));
        end
        send_command(generate_item(16'h0000));
        send_command(generate_item(16'hFFFF));
        finish_phase();

        configure(16'hFFFF, 5'd16);
        send_command(generate_item(16'hFFFF));
        send_command(generate_item(16'h0001));
        send_command(generate_item(16'h8000));
        send_command(load_item(4'd3, 16'hFFFF, 16'sh7FFF, 16'sh8000));
        send_command(generate_item(16'hFFFE));
        finish_phase();

        configure(16'h0000, 5'd0);
        send_command(generate_item(16'($urandom)));
        finish_phase();

        configure(16'h0000, 5'd31);
        send_command(generate_item(16'hFFFF));
        finish_phase();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: configure(16'($urandom_range(2, 40)), 5'($urandom_range(1, 4)));
                1: configure(16'hFFFF, 5'd31);
                2:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct = 6;
                    configure(16'($urandom_range(1, 65535)), 5'($urandom_range(0, 31)));
                end
                3: configure(16'(1 << $urandom_range(1, 15)), 5'($urandom_range(1, 16)));
                4:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    configure(16'h0000, 5'($urandom_range(1, 16)));
                end
                default:
                begin
                    configure(16'($urandom_range(100, 65535)), 5'($urandom_range(4, 8)));
                    hold_off_request = 1'b1;
                end
            endcase
            run_random(RANDOM_PER_PHASE);
            finish_phase();
        end

        $display("Covered %0d loads and %0d generates, %0d points checked over ten settings.",
                 scoreboard.loads_seen, scoreboard.generates_seen, scoreboard.points_checked);
        $display("Settings spanned lattice sizes 0 to 65535 and 0 to 31 dimensions, "
                 , "with a long output hold-off.");
        if (scoreboard.mismatches == 0)
            $display("lattice_rule_point_generator verification clean");
        else
            $display("lattice_rule_point_generator verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lrpg_pkg.sv
rtl/core/lrpg_ram.sv
rtl/core/lrpg_div.sv
rtl/core/lrpg_seq.sv
rtl/core/lattice_rule_point_generator.sv
tb/sv/lattice_rule_point_generator_test.sv
